### hw/rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants of the page table builder.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int PoolTables   = 64;
    localparam int TableEntries = 512;
    localparam int NumTables    = PoolTables + 1;
    localparam int StoreDepth   = NumTables * TableEntries;
    localparam int AddrW        = $clog2(StoreDepth);
    localparam int TableW       = $clog2(NumTables);
    localparam int CountW       = $clog2(PoolTables + 1);
    localparam int EntryW       = 43;
    localparam int FrameW       = 40;

    localparam logic [1:0] KIND_MAP4K = 2'd0;
    localparam logic [1:0] KIND_MAP2M = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOPOOL  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;
    localparam logic [1:0] ST_NOTMAP  = 2'd3;

    // stored entry: frame, page size, write, present
    typedef struct packed {
        logic [FrameW-1:0] frame;
        logic              big_page;
        logic              write;
        logic              present;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] virtual_addr;
        logic [51:0] physical_addr;
        logic [31:0] page_count;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [51:0]       entry_word;
        logic              large_leaf;
        logic [CountW-1:0] tables_used;
    } rsp_t;

    // memory request from walker to store
    typedef struct packed {
        logic             rd;
        logic             wr;
        logic [AddrW-1:0] addr;
        entry_t           wdata;
    } mreq_t;

endpackage

### hw/rtl/page_table_builder.sv
// ----------------------------------------------------------------------------
// page_table_builder
// Builds four-level page tables in an on-chip table store.
// ----------------------------------------------------------------------------
// a map walks and writes one leaf per 4 KiB page or per 2 MiB step,
//   a read walks down to the leaf, an unused kind goes straight to the result
// throughput: one command at a time, busy stays high through the result cycle
// reset: the table store is swept clear after reset, busy is high then
// results are strobed for one cycle; the receiver cannot stall
module page_table_builder
    import ptb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [39:0] cfg_data
);

    logic [FrameW-1:0] base_reg;
    mreq_t             req;
    entry_t            rdata;
    logic              clear_done, active, go;

    // pool base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= '0;
        else if (cfg_valid && cfg_ready)
            base_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;
    assign busy      = active || !clear_done;
    assign go        = start && !busy;

    ptb_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rdata      (rdata),
        .clear_done (clear_done)
    );

    ptb_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .cmd       (cmd),
        .pool_base (base_reg),
        .rdata     (rdata),
        .req       (req),
        .active    (active),
        .done      (done),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy)
        else $error("busy not raised after start");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result while idle");
    a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_OK |-> rsp.entry_word == '0)
        else $error("entry on failed command");
`endif

endmodule

### hw/rtl/ptb_store.sv
// ----------------------------------------------------------------------------
// ptb_store
// Table store memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module ptb_store
    import ptb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  mreq_t  req,
    output entry_t rdata,
    output logic   clear_done
);

    entry_t           mem [StoreDepth];
    logic [AddrW-1:0] clr_reg;
    logic             done_reg;

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (!done_reg)
        begin
            if (clr_reg == AddrW'(StoreDepth - 1))
                done_reg <= 1'b1;
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // single port memory
    always_ff @(posedge clk)
    begin
        if (!done_reg)
            mem[clr_reg] <= '0;
        else if (req.wr)
            mem[req.addr] <= req.wdata;
        if (req.rd)
            rdata <= mem[req.addr];
    end

    assign clear_done = done_reg;

`ifndef SYNTHESIS
    a_no_access_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !done_reg |-> !(req.wr || req.rd))
        else $error("store access during clear");
    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("clear done dropped");
    a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr && req.rd))
        else $error("read and write together");
`endif

endmodule

### hw/rtl/ptb_walker.sv
// ----------------------------------------------------------------------------
// ptb_walker
// Sequencer that walks the tables and reads, modifies and writes entries.
// ----------------------------------------------------------------------------
module ptb_walker
    import ptb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  cmd_t              cmd,
    input  logic [FrameW-1:0] pool_base,
    input  entry_t            rdata,
    output mreq_t             req,
    output logic              active,
    output logic              done,
    output rsp_t              rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_LEAF  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        kind_reg;
    logic [48:0]       v_reg, v_next;
    logic [51:0]       p_reg, p_next;
    logic [63:0]       end_reg;
    logic [1:0]        lvl_reg, lvl_next;
    logic [TableW-1:0] tbl_reg, tbl_next;
    logic [CountW-1:0] used_reg, used_next;
    logic [1:0]        st_reg, st_next;
    logic [51:0]       word_reg, word_next;
    logic              lg_reg, lg_next;
    logic [63:0]       vext;

    logic [8:0]        idx;
    logic [FrameW-1:0] off;
    logic              large_kind, is_leaf_lvl, want_create;
    logic [48:0]       step;

    // address keeps a carry bit so a range may run past the top of the space
    assign vext       = {15'd0, v_reg};
    assign large_kind = (kind_reg == KIND_MAP2M);
    assign step       = large_kind ? 49'h20_0000 : 49'h1000;
    assign off        = rdata.frame - pool_base;
    assign want_create = (kind_reg != KIND_READ);
    // level index: lvl 3..0 selects bits
    always_comb
    begin
        unique case (lvl_reg)
            2'd3: idx = v_reg[47:39];
            2'd2: idx = v_reg[38:30];
            2'd1: idx = v_reg[29:21];
            default: idx = v_reg[20:12];
        endcase
    end
    // leaf level is 1 for large maps, 0 for small maps
    assign is_leaf_lvl = (lvl_reg == 2'd0) || (large_kind && lvl_reg == 2'd1);

    // command registers
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            kind_reg <= cmd.kind;
            end_reg  <= {16'd0, cmd.virtual_addr} + {20'd0, cmd.page_count, 12'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        p_reg    <= p_next;
        lvl_reg  <= lvl_next;
        tbl_reg  <= tbl_next;
        st_reg   <= st_next;
        word_reg <= word_next;
        lg_reg   <= lg_next;
    end

    // walk sequencer
    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        p_next     = p_reg;
        lvl_next   = lvl_reg;
        tbl_next   = tbl_reg;
        used_next  = used_reg;
        st_next    = st_reg;
        word_next  = word_reg;
        lg_next    = lg_reg;
        req        = '0;
        req.addr   = AddrW'({tbl_reg, idx});
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    v_next    = {1'b0, cmd.virtual_addr};
                    p_next    = cmd.physical_addr;
                    st_next   = ST_OK;
                    word_next = '0;
                    lg_next   = 1'b0;
                    if (cmd.kind == KIND_MAP4K || cmd.kind == KIND_MAP2M
                        || cmd.kind == KIND_READ)
                        state_next = S_CHECK;
                    else
                        state_next = S_DONE;
                end
            end
            // range check for maps, then start walk at level 4
            S_CHECK:
            begin
                lvl_next = 2'd3;
                tbl_next = '0;
                if (kind_reg == KIND_READ || vext < end_reg)
                    state_next = S_READ;
                else
                    state_next = S_DONE;
            end
            S_READ:
            begin
                if (want_create && is_leaf_lvl)
                    state_next = S_LEAF;
                else
                begin
                    req.rd     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_READ;
                if (rdata.present)
                begin
                    // a read ends at a level-1 entry or at a level-2 large entry
                    if (kind_reg == KIND_READ
                        && (lvl_reg == 2'd0 || (lvl_reg == 2'd1 && rdata.big_page)))
                    begin
                        word_next  = {rdata.frame, 4'd0, rdata.big_page, 5'd0,
                                      rdata.write, rdata.present};
                        lg_next    = rdata.big_page & (lvl_reg == 2'd1);
                        state_next = S_DONE;
                    end
                    else if (rdata.big_page || off >= FrameW'(used_reg))
                    begin
                        st_next    = ST_OUTSIDE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        tbl_next = TableW'(off) + 1'b1;
                        lvl_next = lvl_reg - 1'b1;
                    end
                end
                else if (!want_create)
                begin
                    st_next    = ST_NOTMAP;
                    state_next = S_DONE;
                end
                else if (used_reg >= CountW'(PoolTables))
                begin
                    st_next    = ST_NOPOOL;
                    state_next = S_DONE;
                end
                else
                begin
                    req.wr          = 1'b1;
                    req.wdata       = '0;
                    req.wdata.present = 1'b1;
                    req.wdata.write = 1'b1;
                    req.wdata.frame = pool_base + FrameW'(used_reg);
                    tbl_next        = TableW'(used_reg) + 1'b1;
                    used_next       = used_reg + 1'b1;
                    lvl_next        = lvl_reg - 1'b1;
                end
            end
            // write leaf and step to the next page
            S_LEAF:
            begin
                req.wr             = 1'b1;
                req.wdata          = '0;
                req.wdata.present  = 1'b1;
                req.wdata.write    = 1'b1;
                req.wdata.big_page = large_kind;
                req.wdata.frame    = p_reg[51:12];
                v_next             = v_reg + step;
                p_next             = p_reg + {3'd0, step};
                state_next         = S_CHECK;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign active          = (state_reg != S_IDLE);
    assign done            = (state_reg == S_DONE);
    assign rsp.status      = st_reg;
    assign rsp.entry_word  = (st_reg == ST_OK) ? word_reg : '0;
    assign rsp.large_leaf  = (st_reg == ST_OK) & lg_reg;
    assign rsp.tables_used = used_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CountW'(PoolTables))
        else $error("pool count overflow");
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != $past(used_reg) |-> used_reg == $past(used_reg) + 1'b1)
        else $error("pool count jumped");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !active)
        else $error("walk not closed");
`endif

endmodule
